// ===== hdl/fsba_pkg.sv =====
// Package of the free-space bitmap allocator: field widths, command codes,
// the decoded operation type and the status structs shared by the modules.
// Depends on nothing.
package fsba_pkg;

    localparam int POS_W   = 12;
    localparam int LEN_W   = 13;
    localparam int LAST_W  = 14;
    localparam int CHUNK_W = 8;

    localparam logic [1:0] CMD_MARK = 2'd0;
    localparam logic [1:0] CMD_FIND = 2'd1;
    localparam logic [1:0] CMD_TEST = 2'd2;

    typedef enum logic [1:0] {
        K_NOP,
        K_MARK,
        K_FIND,
        K_TEST
    } t_kind;

    // skip: a mark that touches nothing, or a test beyond the map.
    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   pos;
        logic [LEN_W-1:0]   len;
        logic               used;
        logic               skip;
        logic [LAST_W-1:0]  last;
    } t_op;

    typedef struct packed {
        logic [POS_W-1:0] found_pos;
        logic             found;
        logic             position_free;
    } t_result;

    typedef struct packed {
        logic [POS_W-1:0] search_start;
        logic [LEN_W-1:0] disk_size;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// ===== hdl/fsba_if.sv =====
// Valid/ready channels of the allocator: command words in, result words out.
// Depends on fsba_pkg.
interface fsba_in_if import fsba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [POS_W-1:0]   start_pos;
    logic [LEN_W-1:0]   run_length;
    logic               mark_used;

    modport source (output valid, cmd, start_pos, run_length, mark_used, input ready);
    modport sink (input valid, cmd, start_pos, run_length, mark_used, output ready);
endinterface

interface fsba_out_if import fsba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   found_pos;
    logic               found;
    logic               position_free;

    modport source (output valid, found_pos, found, position_free, input ready);
    modport sink (input valid, found_pos, found, position_free, output ready);
endinterface

// ===== hdl/free_space_bitmap_allocator.sv =====
// Operations: a test reads one 32-bit word; a mark reads and rewrites every
// 32-bit word it touches; a find reads each 32-bit word it scans in turn.
// Throughput: one operation at a time; a find is bound by the single
// RAM read port and the run counter, which walks eight bits a cycle.
// Reset: synchronous, active low; afterwards a clearing sweep writes the
// bitmap's POSITIONS/32 words (128 by default) free; no word is accepted.
module free_space_bitmap_allocator import fsba_pkg::*; #(
    parameter int POSITIONS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsba_in_if.sink     i_in,
    fsba_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register index taken from the word address of the APB port.
    localparam logic REG_SEARCH_START = 1'b0;
    localparam logic REG_DISK_SIZE    = 1'b1;

    t_cfg       r_cfg;
    t_back_stat stat;
    t_op        op;
    logic       op_valid;
    logic       pop;
    logic       cfg_wr;

    // Configuration is written at the access phase of an APB write. The user
    // must write only while the block is idle; the block does not enforce it.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.search_start <= '0;
            r_cfg.disk_size    <= 13'd4096;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SEARCH_START: r_cfg.search_start <= pwdata[POS_W-1:0];
                REG_DISK_SIZE:    r_cfg.disk_size    <= pwdata[LEN_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SEARCH_START: prdata = {{(32 - POS_W){1'b0}}, r_cfg.search_start};
            REG_DISK_SIZE:    prdata = {{(32 - LEN_W){1'b0}}, r_cfg.disk_size};
            default:          prdata = '0;
        endcase
    end

    // The front end decodes and queues commands; the back end owns the
    // bitmap and the result register, so either side may stall on its own.
    fsba_front #(.POSITIONS(POSITIONS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_stat     (stat),
        .i_pop      (pop),
        .o_op_valid (op_valid),
        .o_op       (op)
    );

    fsba_back #(.POSITIONS(POSITIONS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_pop      (pop),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule

// ===== hdl/fsba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fsba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fsba_front.sv =====
// Front end: accepts command words, decodes them into operations and holds
// them in a two-entry queue for the back end. Depends on fsba_pkg, fsba_if.
module fsba_front import fsba_pkg::*; #(
    parameter int POSITIONS = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsba_in_if.sink    i_in,
    input  t_back_stat i_stat,
    input  logic       i_pop,
    output logic       o_op_valid,
    output t_op        o_op
);

    localparam int AW = $clog2(POSITIONS);
    localparam int PW = (AW + 1 > 14) ? AW + 1 : 14;
    localparam logic [1:0] Q_FULL = 2'd2;

    t_op         r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_count;
    t_op         dec;
    logic [PW-1:0] sum;
    logic [PW-1:0] stop;
    logic        push;

    // Decode the incoming word and work out the last position a mark touches.
    always_comb begin
        dec.pos  = i_in.start_pos;
        dec.len  = i_in.run_length;
        dec.used = i_in.mark_used;
        sum  = PW'(i_in.start_pos) + PW'(i_in.run_length);
        stop = (sum > PW'(POSITIONS)) ? PW'(POSITIONS) : sum;
        dec.last = LAST_W'(stop - PW'(1));
        case (i_in.cmd)
            CMD_MARK: begin
                dec.kind = K_MARK;
                dec.skip = (i_in.run_length == '0) ||
                           (PW'(i_in.start_pos) >= PW'(POSITIONS));
            end
            CMD_FIND: begin
                dec.kind = K_FIND;
                dec.skip = 1'b0;
            end
            CMD_TEST: begin
                dec.kind = K_TEST;
                dec.skip = PW'(i_in.start_pos) >= PW'(POSITIONS);
            end
            default: begin
                dec.kind = K_NOP;
                dec.skip = 1'b0;
            end
        endcase
    end

    assign i_in.ready = (r_count != Q_FULL) && !i_stat.clearing;
    assign push       = i_in.valid && i_in.ready;
    assign o_op_valid = r_count != 2'd0;
    assign o_op       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== hdl/fsba_back.sv =====
// Back end: owns the bitmap RAM, clears it after reset, carries out mark,
// test and first-fit find, and holds the result word. Depends on fsba_pkg,
// fsba_if and fsba_ram.
module fsba_back import fsba_pkg::*; #(
    parameter int POSITIONS = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_pop,
    output t_back_stat o_stat,
    fsba_out_if.source o_out
);

    localparam int AW    = $clog2(POSITIONS);
    localparam int WW    = (POSITIONS < 32) ? POSITIONS : 32;
    localparam int OW    = $clog2(WW);
    localparam int WORDS = POSITIONS / WW;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NCH   = WW / CHUNK_W;
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PW    = (AW + 1 > 14) ? AW + 1 : 14;

    typedef enum logic [7:0] {
        S_CLEAR      = 8'b0000_0001,
        S_IDLE       = 8'b0000_0010,
        S_MARK_RD    = 8'b0000_0100,
        S_MARK_WR    = 8'b0000_1000,
        S_TEST_CHK   = 8'b0001_0000,
        S_FIND_RD    = 8'b0010_0000,
        S_FIND_CHUNK = 8'b0100_0000,
        S_DONE       = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [WA-1:0]   r_word, n_word;
    logic [CHW-1:0]  r_chunk, n_chunk;
    logic [LEN_W-1:0] r_run, n_run;
    t_op             r_op, n_op;
    logic [PW-1:0]   r_limit, n_limit;
    t_result         r_res, n_res;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            ram_we, ram_re;
    logic [WA-1:0]   ram_waddr, ram_raddr;
    logic [WW-1:0]   ram_wdata, ram_rdata;

    logic [WA-1:0]   first_w, last_w;
    logic [OW-1:0]   lo, hi;
    logic [WW-1:0]   mask;
    logic [PW-1:0]   lim, base, p, hit_pos, where;
    logic [CHUNK_W-1:0] cbits;
    logic [LEN_W-1:0] run;
    logic            hit, stop_f;

    fsba_ram #(.WIDTH(WW), .DEPTH(WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.clearing   = r_state == S_CLEAR;
    assign o_pop             = (r_state == S_IDLE) && i_op_valid;
    assign o_out.valid        = r_out_valid;
    assign o_out.found_pos    = r_out.found_pos;
    assign o_out.found        = r_out.found;
    assign o_out.position_free = r_out.position_free;

    // Mark masks and the run counter of the find scan, which walks eight-bit chunks.
    always_comb begin
        first_w = WA'(PW'(r_op.pos) >> OW);
        last_w  = WA'(PW'(r_op.last) >> OW);
        lo   = (r_word == first_w) ? r_op.pos[OW-1:0] : '0;
        hi   = (r_word == last_w) ? r_op.last[OW-1:0] : OW'(WW - 1);
        mask = ({WW{1'b1}} << lo) & ({WW{1'b1}} >> (OW'(WW - 1) - hi));
        lim  = (PW'(i_cfg.disk_size) > PW'(POSITIONS)) ? PW'(POSITIONS)
                                                       : PW'(i_cfg.disk_size);
        cbits = ram_rdata[CHUNK_W*r_chunk +: CHUNK_W];
        base  = (PW'(r_word) << OW) + (PW'(r_chunk) << 3);
        run     = r_run;
        hit     = 1'b0;
        stop_f  = 1'b0;
        hit_pos = '0;
        p       = '0;
        for (int b = 0; b < CHUNK_W; b++) begin
            p = base + PW'(b);
            if (!hit && !stop_f) begin
                if (p >= r_limit) begin
                    stop_f = 1'b1;
                end else if (p >= PW'(i_cfg.search_start)) begin
                    if (!cbits[b]) begin
                        run = run + LEN_W'(1);
                        if (run == r_op.len) begin
                            hit     = 1'b1;
                            hit_pos = p;
                        end
                    end else begin
                        run = '0;
                    end
                end
            end
        end
        where = hit_pos + PW'(1) - PW'(r_op.len);
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_chunk     = r_chunk;
        n_run       = r_run;
        n_op        = r_op;
        n_limit     = r_limit;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        ram_we      = 1'b0;
        ram_waddr   = r_word;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_word;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_word = r_word + WA'(1);
                if (r_word == WA'(WORDS - 1)) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_op_valid) begin
                    n_op    = i_op;
                    n_res   = '0;
                    n_run   = '0;
                    n_chunk = '0;
                    n_limit = lim;
                    n_state = S_DONE;
                    case (i_op.kind)
                        K_MARK: begin
                            if (!i_op.skip) begin
                                n_word  = WA'(PW'(i_op.pos) >> OW);
                                n_state = S_MARK_RD;
                            end
                        end
                        K_TEST: begin
                            if (!i_op.skip) begin
                                ram_re    = 1'b1;
                                ram_raddr = WA'(PW'(i_op.pos) >> OW);
                                n_state   = S_TEST_CHK;
                            end
                        end
                        K_FIND: begin
                            if (i_op.len == '0) begin
                                n_res.found     = 1'b1;
                                n_res.found_pos = i_cfg.search_start;
                            end else if (PW'(i_cfg.search_start) < lim) begin
                                n_word  = WA'(PW'(i_cfg.search_start) >> OW);
                                n_state = S_FIND_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MARK_RD: begin
                ram_re  = 1'b1;
                n_state = S_MARK_WR;
            end
            S_MARK_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_op.used ? (ram_rdata | mask) : (ram_rdata & ~mask);
                if (r_word == last_w) begin
                    n_state = S_DONE;
                end else begin
                    n_word  = r_word + WA'(1);
                    n_state = S_MARK_RD;
                end
            end
            S_TEST_CHK: begin
                n_res.position_free = !ram_rdata[r_op.pos[OW-1:0]];
                n_state = S_DONE;
            end
            S_FIND_RD: begin
                ram_re  = 1'b1;
                n_chunk = '0;
                n_state = S_FIND_CHUNK;
            end
            S_FIND_CHUNK: begin
                n_run = run;
                if (hit) begin
                    n_res.found     = 1'b1;
                    n_res.found_pos = where[POS_W-1:0];
                    n_state = S_DONE;
                end else if (stop_f) begin
                    n_state = S_DONE;
                end else if (r_chunk == CHW'(NCH - 1)) begin
                    if (r_word == WA'(WORDS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_word  = r_word + WA'(1);
                        n_state = S_FIND_RD;
                    end
                end else begin
                    n_chunk = r_chunk + CHW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_chunk <= n_chunk;
        r_run   <= n_run;
        r_op    <= n_op;
        r_limit <= n_limit;
        r_res   <= n_res;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("operation taken during the clearing sweep");
    a_no_write_on_read_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST_CHK || r_state == S_FIND_RD || r_state == S_FIND_CHUNK)
        |-> !ram_we)
        else $error("bitmap written during test or find");
    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("operation taken but not started");
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> r_out_valid)
        else $error("finished result not loaded into the output register");
`endif

endmodule

// ===== tb/sv/tb_free_space_bitmap_allocator.sv =====
// Self-checking testbench of the free-space bitmap allocator: drives command
// words and APB register writes, predicts every result word from a bitmap model.
// Depends on fsba_pkg, fsba_if and the free_space_bitmap_allocator RTL.
module tb_free_space_bitmap_allocator;
    import fsba_pkg::*;

    localparam int NPOS        = 4096;
    localparam logic [2:0] ADDR_START = 3'd0;
    localparam logic [2:0] ADDR_SIZE  = 3'd4;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fsba_in_if  cmd_ch ();
    fsba_out_if res_ch ();

    free_space_bitmap_allocator #(.POSITIONS(NPOS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cmd_ch.sink), .o_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // Model of the bitmap and its registers, 1 marks a used position.
    bit [NPOS-1:0]    used_map;
    bit [POS_W-1:0]   model_start;
    bit [LEN_W-1:0]   model_size;
    t_result          pending_results[$];

    int  error_count = 0;
    int  result_count = 0;
    int  word_count = 0;
    int  cycle_count = 0;
    bit  idle_enable = 1'b1;
    int  hold_off = 0;

    function automatic t_result predict_word(logic [1:0] cmd, logic [POS_W-1:0] pos,
                                             logic [LEN_W-1:0] len, logic used);
        t_result r;
        int lim;
        int run;
        r = '0;
        run = 0;
        case (cmd)
            CMD_MARK: begin
                for (int p = pos; p < NPOS && p < pos + len; p++) used_map[p] = used;
            end
            CMD_FIND: begin
                lim = (model_size > NPOS) ? NPOS : model_size;
                if (len == 0) begin
                    r.found = 1'b1;
                    r.found_pos = model_start;
                end else begin
                    for (int p = model_start; p < lim; p++) begin
                        run = used_map[p] ? 0 : run + 1;
                        if (run == len) begin
                            r.found = 1'b1;
                            r.found_pos = POS_W'(p + 1 - len);
                            break;
                        end
                    end
                end
            end
            CMD_TEST: r.position_free = !used_map[pos];
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH word %0d: %s got %0d expected %0d", result_count, what, got, want);
        error_count++;
    endtask

    // Result checker: the receiver stalls at random, or for a long stretch on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", 1, 0);
                end else begin
                    t_result w;
                    w = pending_results.pop_front();
                    if (res_ch.found_pos !== w.found_pos)
                        report_mismatch("found_pos", res_ch.found_pos, w.found_pos);
                    if (res_ch.found !== w.found)
                        report_mismatch("found", res_ch.found, w.found);
                    if (res_ch.position_free !== w.position_free)
                        report_mismatch("position_free", res_ch.position_free,
                                        w.position_free);
                end
                result_count++;
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(idle_enable && $urandom_range(99) < 11);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one command word; the prediction is made at the accepting edge.
    // Valid stays high after acceptance until the next word or an idle cycle
    // replaces it, so each edge sees a single assignment.
    task automatic send_word(logic [1:0] cmd, logic [POS_W-1:0] pos,
                             logic [LEN_W-1:0] len, logic used);
        while (idle_enable && $urandom_range(99) < 11) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= cmd;
        cmd_ch.start_pos <= pos;
        cmd_ch.run_length <= len;
        cmd_ch.mark_used <= used;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_results.push_back(predict_word(cmd, pos, len, used));
        word_count++;
    endtask

    task automatic drain;
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    // APB write: setup then access; the block is idle whenever this is called.
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_START) model_start = data[POS_W-1:0];
        else if (addr == ADDR_SIZE) model_size = data[LEN_W-1:0];
    endtask

    task automatic set_config(int start, int size);
        drain();
        write_reg(ADDR_START, start);
        write_reg(ADDR_SIZE, size);
    endtask

    task automatic test_directed;
        send_word(CMD_TEST, 12'd0, 13'd0, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd0, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd4096, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd4097, 1'b0);
        send_word(CMD_MARK, 12'd4090, 13'd8191, 1'b1);
        send_word(CMD_TEST, 12'd4095, 13'd0, 1'b1);
        send_word(CMD_MARK, 12'd3, 13'd5, 1'b1);
        send_word(CMD_MARK, 12'd100, 13'd0, 1'b1);
        send_word(CMD_TEST, 12'd7, 13'd0, 1'b0);
        send_word(CMD_TEST, 12'd8, 13'd0, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd4, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd3, 1'b0);
        send_word(CMD_NONE, 12'hFFF, 13'h1FFF, 1'b1);
        send_word(CMD_MARK, 12'd5, 13'd1, 1'b0);
        send_word(CMD_TEST, 12'd5, 13'd0, 1'b0);
        send_word(CMD_MARK, 12'd0, 13'd4096, 1'b0);
        send_word(CMD_FIND, 12'hFFF, 13'd1, 1'b0);
    endtask

    // Register extremes: start at the top, tiny disk, disk beyond the map.
    task automatic test_registers;
        set_config(4095, 4096);
        send_word(CMD_FIND, 12'd0, 13'd1, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd2, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd0, 1'b0);
        set_config(10, 1);
        send_word(CMD_FIND, 12'd0, 13'd1, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd0, 1'b0);
        set_config(0, 8191);
        send_word(CMD_FIND, 12'd0, 13'd4096, 1'b0);
        set_config(64, 200);
        send_word(CMD_MARK, 12'd70, 13'd3, 1'b1);
        send_word(CMD_FIND, 12'd0, 13'd10, 1'b0);
        send_word(CMD_FIND, 12'd0, 13'd137, 1'b0);
        set_config(0, 4096);
        send_word(CMD_MARK, 12'd0, 13'd4096, 1'b0);
    endtask

    // Random words: mostly marks and finds with small lengths over a fragmented map.
    task automatic test_random(int n);
        logic [1:0]       cmd;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             used;
        int sel;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) begin
                set_config($urandom_range(0, 300), $urandom_range(1000, 8191));
                idle_enable = 1'b0;
            end
            if (i == n / 2) idle_enable = 1'b1;
            if (i == 2 * n / 3) set_config($urandom_range(0, 4095), $urandom_range(1, 4096));
            sel = $urandom_range(99);
            pos = POS_W'($urandom);
            used = 1'($urandom);
            cmd = sel < 40 ? CMD_MARK : sel < 70 ? CMD_FIND : sel < 97 ? CMD_TEST : CMD_NONE;
            len = ($urandom_range(19) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 40));
            send_word(cmd, pos, len, used);
        end
    endtask

    // Receiver holds off long enough that the block fills up and stalls its input.
    task automatic test_backpressure;
        hold_off = 400;
        for (int i = 0; i < 12; i++) send_word(CMD_TEST, POS_W'($urandom), 13'd0, 1'b0);
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_MARK;
        cmd_ch.start_pos = '0;
        cmd_ch.run_length = '0;
        cmd_ch.mark_used = 1'b0;
        res_ch.ready = 1'b0;
        used_map = '0;
        model_start = '0;
        model_size = 13'd4096;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_registers();
        test_backpressure();
        test_random(480);
        drain();
        $display("Covered %0d command words and %0d result words, including marks, finds,",
                 word_count, result_count);
        $display("tests, the unused command, register extremes and a long receiver stall.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/fsba_pkg.sv
hdl/fsba_if.sv
hdl/fsba_ram.sv
hdl/fsba_front.sv
hdl/fsba_back.sv
hdl/free_space_bitmap_allocator.sv
tb/sv/tb_free_space_bitmap_allocator.sv
